// File: src/lrukv_pkg.sv
// lrukv_pkg: shared types and constants for the LRU key/value cache.
// Request/result payload structs, controller/datapath command and status.
// No dependencies.
`default_nettype none

package lrukv_pkg;

	localparam int DATA_W      = 32;
	localparam int CAP_W       = 5;
	localparam int DEF_ENTRIES = 16;
	localparam int CAP_RESET   = 16;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [DATA_W-1:0] MISS_VALUE   = '1;
	localparam logic [0:0]        REG_CAPACITY = 1'b0;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef struct packed {
		op_t                      opcode;
		logic signed [DATA_W-1:0] lookup_key;
		logic signed [DATA_W-1:0] write_value;
	} req_t;

	typedef struct packed {
		logic                     hit;
		logic signed [DATA_W-1:0] read_value;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic upd;
		logic decide;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic need_upd;
		logic empty;
	} sts_t;

endpackage

`default_nettype wire

// File: src/lru_key_value_cache.sv
// lru_key_value_cache: fully associative key/value cache, LRU replacement.
// Top level: APB register, sequencer and datapath. Depends on lrukv_pkg,
// lrukv_ctrl, lrukv_dp (which holds lrukv_ram).
//
//   channel   | handshake                     | payload
//   ----------+-------------------------------+----------------------------------
//   request   | start && !busy                | opcode, lookup_key, write_value
//   result    | done (one cycle, no stall)    | hit, read_value
//   config    | psel & penable & pwrite       | cache_capacity at 0x0
//
// Each transaction scans every entry through the RAM read port, one a cycle.
// A get miss ends after the lookup pass; a hit or put adds a second pass
// rewriting ranks. done rises as busy falls; the next start may be
// accepted in that same cycle. Reset clears valid bits, count and control;
// no clearing pass. The receiver cannot stall: each result is shown once.
`default_nettype none

module lru_key_value_cache import lrukv_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output      logic [PDATA_W-1:0] prdata,
	output      logic               pready,
	input  wire logic               start,
	output      logic               busy,
	input  wire req_t               request,
	output      logic               done,
	output      rsp_t               result
);

	localparam logic [CAP_W-1:0] CapMax   = CAP_W'((ENTRIES > 31) ? 31 : ENTRIES);
	localparam logic [CAP_W-1:0] CapReset = CAP_W'((CAP_RESET < ENTRIES) ? CAP_RESET
	                                                                     : ENTRIES);

	logic [CAP_W-1:0] cap_q;
	logic [CAP_W-1:0] cap_wr;
	logic             apb_wr;
	cmd_t             cmd;
	sts_t             sts;

	assign pready = 1'b1;
	assign apb_wr = psel && penable && pwrite && pready;

	always_comb begin
		if (pwdata[CAP_W-1:0] == '0) begin
			cap_wr = CAP_W'(1);
		end else if (pwdata[CAP_W-1:0] > CapMax) begin
			cap_wr = CapMax;
		end else begin
			cap_wr = pwdata[CAP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CapReset;
		end else if (apb_wr && (paddr[2:2] == REG_CAPACITY) && sts.empty) begin
			cap_q <= cap_wr;
		end
	end

	assign prdata = (paddr[2:2] == REG_CAPACITY) ? PDATA_W'(cap_q) : '0;

	lrukv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	lrukv_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.request (request),
		.cap     (cap_q),
		.result  (result)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a transaction in flight");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted transaction did not raise busy");

	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |-> (result.read_value == $signed(MISS_VALUE)))
		else $error("miss returned a value other than -1");

endmodule

`default_nettype wire

// File: src/lrukv_ram.sv
// lrukv_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`default_nettype none

module lrukv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        waddr,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic                 re,
	input  wire logic [AW-1:0]        raddr,
	output      logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: src/lrukv_ctrl.sv
// lrukv_ctrl: request sequencer; lookup pass, decision, rank update pass.
// Depends on lrukv_pkg.
`default_nettype none

module lrukv_ctrl import lrukv_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output      logic busy,
	output      logic done,
	input  wire sts_t sts,
	output      cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SDRAIN,
		ST_DECIDE,
		ST_UPD,
		ST_UDRAIN
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.last) begin
						state_q <= ST_SDRAIN;
					end
				end
				ST_SDRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (sts.need_upd) begin
						state_q <= ST_UPD;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_UPD: begin
					if (sts.last) begin
						state_q <= ST_UDRAIN;
					end
				end
				ST_UDRAIN: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign cmd.load   = (state_q == ST_IDLE) && start;
	assign cmd.rd     = (state_q == ST_SCAN) || (state_q == ST_UPD);
	assign cmd.upd    = (state_q == ST_UPD);
	assign cmd.decide = (state_q == ST_DECIDE);

endmodule

`default_nettype wire

// File: src/lrukv_dp.sv
// lrukv_dp: entry store (key, value, rank in RAM; valid bits in flops),
// lookup scan, victim/free-slot selection and rank update pass.
// Depends on lrukv_pkg, lrukv_ram.
`default_nettype none

module lrukv_dp import lrukv_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd,
	output      sts_t             sts,
	input  wire req_t             request,
	input  wire logic [CAP_W-1:0] cap,
	output      rsp_t             result
);

	localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RW   = IW;
	localparam int CW   = $clog2(ENTRIES + 1);
	localparam int WW   = 2 * DATA_W + RW;
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
	localparam int VW   = (CW > RW) ? CW : RW;

	logic [IW-1:0]      ptr_q;
	logic               last;
	logic [IW-1:0]      idx_s1;
	logic               act_s1;
	logic               upd_s1;
	logic [WW-1:0]      rdata;
	logic [WW-1:0]      wdata;
	logic               we;

	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] valid_nx;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      cnt_m1;

	op_t                op_q;
	logic [DATA_W-1:0]  key_q;
	logic [DATA_W-1:0]  wval_q;
	logic               hit_q;
	logic [DATA_W-1:0]  val_q;
	logic [IW-1:0]      slot_q;
	logic [RW-1:0]      hrank_q;
	logic               vic_found_q;
	logic [IW-1:0]      vic_q;
	logic               free_found_q;
	logic [IW-1:0]      free_q;

	logic [DATA_W-1:0]  e_key;
	logic [DATA_W-1:0]  e_val;
	logic [RW-1:0]      e_rank;
	logic               e_valid;
	logic               scan_act;
	logic               match;
	logic               vic_hit;
	logic               free_hit;
	logic               evict;
	logic               insert;
	logic [IW-1:0]      new_slot;

	lrukv_ram #(
		.WIDTH (WW),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (idx_s1),
		.wdata (wdata),
		.re    (cmd.rd),
		.raddr (ptr_q),
		.rdata (rdata)
	);

	assign last     = (ptr_q == IW'(ENTRIES - 1));
	assign e_key    = rdata[WW-1 -: DATA_W];
	assign e_val    = rdata[RW +: DATA_W];
	assign e_rank   = rdata[RW-1:0];
	assign e_valid  = valid_q[idx_s1];
	assign cnt_m1   = count_q - CW'(1);
	assign scan_act = act_s1 && !upd_s1;
	assign match    = scan_act && e_valid && (e_key == key_q) && !hit_q;
	assign vic_hit  = scan_act && e_valid && (count_q != '0) && !vic_found_q
	                  && (VW'(e_rank) >= VW'(cnt_m1));
	assign free_hit = scan_act && !e_valid && !free_found_q;

	assign evict    = (CMPW'(count_q) >= CMPW'(cap)) && (count_q != '0);
	assign insert   = cmd.decide && !hit_q && (op_q == OP_PUT);
	assign new_slot = (evict && (!free_found_q || (vic_q < free_q))) ? vic_q : free_q;
	assign valid_nx = (evict ? (valid_q & ~(ENTRIES'(1) << vic_q)) : valid_q)
	                  | (ENTRIES'(1) << new_slot);

	assign we = act_s1 && upd_s1;

	always_comb begin
		if (idx_s1 == slot_q) begin
			wdata = {key_q, (op_q == OP_PUT) ? wval_q : e_val, {RW{1'b0}}};
		end else if (e_valid && (!hit_q || (e_rank < hrank_q))) begin
			wdata = {e_key, e_val, e_rank + RW'(1)};
		end else begin
			wdata = rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			act_s1       <= 1'b0;
			upd_s1       <= 1'b0;
			valid_q      <= '0;
			count_q      <= '0;
			hit_q        <= 1'b0;
			vic_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			act_s1 <= cmd.rd;
			upd_s1 <= cmd.upd;
			if (cmd.rd) begin
				ptr_q <= last ? '0 : ptr_q + IW'(1);
			end
			if (cmd.load) begin
				hit_q        <= 1'b0;
				vic_found_q  <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (match) begin
					hit_q <= 1'b1;
				end
				if (vic_hit) begin
					vic_found_q <= 1'b1;
				end
				if (free_hit) begin
					free_found_q <= 1'b1;
				end
			end
			if (insert) begin
				if (!evict) begin
					count_q <= count_q + CW'(1);
				end
				valid_q <= valid_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ptr_q;
		if (cmd.load) begin
			op_q   <= request.opcode;
			key_q  <= request.lookup_key;
			wval_q <= request.write_value;
			val_q  <= MISS_VALUE;
		end else begin
			if (match) begin
				slot_q  <= idx_s1;
				hrank_q <= e_rank;
				if (op_q == OP_GET) begin
					val_q <= e_val;
				end
			end
			if (vic_hit) begin
				vic_q <= idx_s1;
			end
			if (free_hit) begin
				free_q <= idx_s1;
			end
			if (insert) begin
				slot_q <= new_slot;
			end
		end
	end

	assign sts.last       = last;
	assign sts.need_upd   = hit_q || (op_q == OP_PUT);
	assign sts.empty      = (count_q == '0);
	assign result.hit        = hit_q;
	assign result.read_value = $signed(val_q);

endmodule

`default_nettype wire

// File: bench/tb_lru_key_value_cache.sv
// tb_lru_key_value_cache: self-checking bench for the LRU key/value cache.
// Drives get/put transactions and APB capacity writes, predicts each result from
// its own recency model and compares it with done/result. Depends on lrukv_pkg.
`default_nettype none

module tb_lru_key_value_cache import lrukv_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_LINES     = DEF_ENTRIES;
	localparam int STALL_LIMIT = 5000;
	localparam logic [PADDR_W-1:0] CAP_ADDR    = {REG_CAPACITY, 2'b00};
	localparam logic [PADDR_W-1:0] UNUSED_ADDR = {~REG_CAPACITY, 2'b00};

	logic               clk;
	logic               arst_n  = 1'b0;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [PDATA_W-1:0] pwdata  = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               start   = 1'b0;
	logic               busy;
	req_t               request = '0;
	logic               done;
	rsp_t               result;

	lru_key_value_cache dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// predicted cache contents
	logic signed [DATA_W-1:0] line_key [N_LINES];
	logic signed [DATA_W-1:0] line_val [N_LINES];
	logic                     line_valid [N_LINES];
	logic [3:0]               line_rank [N_LINES];
	logic [CAP_W-1:0]         stored_count = '0;
	logic [CAP_W-1:0]         capacity = CAP_W'(CAP_RESET);

	req_t pending_requests [$];
	rsp_t expected_results [$];
	logic signed [DATA_W-1:0] key_pool [$];

	logic idling_on = 1'b0;
	int   gap_left = 0;
	int   stall_cycles = 0;
	int   accepted = 0;
	int   results_checked = 0;
	int   hits_predicted = 0;
	int   evictions_predicted = 0;
	int   mismatches = 0;

	initial begin
		for (int i = 0; i < N_LINES; i++) begin
			line_valid[i] = 1'b0;
		end
	end

	function automatic void make_newest(int s);
		int i;
		for (i = 0; i < N_LINES; i++) begin
			if (line_valid[i] && line_rank[i] < line_rank[s]) begin
				line_rank[i] = line_rank[i] + 4'd1;
			end
		end
		line_rank[s] = '0;
	endfunction

	function automatic rsp_t cache_access(req_t rq);
		rsp_t rs;
		int   slot;
		int   i;
		logic evicted;
		slot = -1;
		evicted = 1'b0;
		for (i = 0; i < N_LINES; i++) begin
			if (slot < 0 && line_valid[i] && line_key[i] == rq.lookup_key) begin
				slot = i;
			end
		end
		rs.hit = (slot >= 0);
		rs.read_value = MISS_VALUE;
		if (slot >= 0) begin
			hits_predicted++;
			if (rq.opcode == OP_GET) begin
				rs.read_value = line_val[slot];
			end else begin
				line_val[slot] = rq.write_value;
			end
			make_newest(slot);
		end else if (rq.opcode == OP_PUT) begin
			if (stored_count >= capacity && stored_count != 0) begin
				for (i = 0; i < N_LINES; i++) begin
					if (!evicted && line_valid[i] && line_rank[i] >= stored_count - 1'b1) begin
						line_valid[i] = 1'b0;
						evicted = 1'b1;
					end
				end
				stored_count = stored_count - 1'b1;
				evictions_predicted++;
			end
			for (i = 0; i < N_LINES; i++) begin
				if (slot < 0 && !line_valid[i]) begin
					slot = i;
				end
			end
			if (slot >= 0) begin
				for (i = 0; i < N_LINES; i++) begin
					if (line_valid[i]) begin
						line_rank[i] = line_rank[i] + 4'd1;
					end
				end
				line_key[slot] = rq.lookup_key;
				line_val[slot] = rq.write_value;
				line_valid[slot] = 1'b1;
				line_rank[slot] = '0;
				stored_count = stored_count + 1'b1;
			end
		end
		return rs;
	endfunction

	function automatic req_t mk_req(op_t op, logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
		req_t rq;
		rq.opcode = op;
		rq.lookup_key = k;
		rq.write_value = v;
		return rq;
	endfunction

	function automatic req_t random_req();
		logic [DATA_W-1:0] k;
		logic [DATA_W-1:0] v;
		if ($urandom_range(0, 7) == 0) begin
			k = $urandom();
		end else begin
			k = key_pool[$urandom_range(0, key_pool.size() - 1)];
		end
		case ($urandom_range(0, 11))
			0: v = 32'h8000_0000;
			1: v = 32'h7fff_ffff;
			2: v = '0;
			3: v = '1;
			default: v = $urandom();
		endcase
		return mk_req($urandom_range(0, 1) ? OP_PUT : OP_GET, k, v);
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left = 0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back(cache_access(request));
				accepted++;
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_requests.size() != 0 && idling_on
						&& $urandom_range(0, 3) == 0) begin
					gap_left = $urandom_range(0, 10);
					start <= 1'b0;
				end else if (pending_requests.size() != 0) begin
					request <= pending_requests.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin : monitor
		rsp_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual hit=%0b value=%h",
					$time, result.hit, result.read_value);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (result.hit !== want.hit) begin
					$display("%0t: hit mismatch: expected %0b, actual %0b",
						$time, want.hit, result.hit);
					mismatches++;
				end
				if (result.read_value !== want.read_value) begin
					$display("%0t: read_value mismatch: expected %h, actual %h",
						$time, want.read_value, result.read_value);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		logic [CAP_W-1:0] raw;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		raw = data[CAP_W-1:0];
		if (addr[PADDR_W-1:2] == REG_CAPACITY && stored_count == 0) begin
			if (raw == 0) begin
				capacity = CAP_W'(1);
			end else if (raw > N_LINES) begin
				capacity = CAP_W'(N_LINES);
			end else begin
				capacity = raw;
			end
		end
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (pending_requests.size() != 0 || start || busy || expected_results.size() != 0);
	endtask

	task automatic run_random(int n, logic with_gaps);
		int pool_size;
		@(negedge clk);
		idling_on = with_gaps;
		pool_size = capacity + $urandom_range(1, 4);
		key_pool.delete();
		for (int i = 0; i < pool_size; i++) begin
			key_pool.push_back($urandom());
		end
		for (int i = 0; i < n; i++) begin
			pending_requests.push_back(random_req());
		end
		wait_drained();
	endtask

	initial begin
		logic [CAP_W-1:0] cap_raw;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// saturation at both ends while empty, then an unmapped address
		apb_write(CAP_ADDR, {27'($urandom()), 5'd0});
		apb_write(CAP_ADDR, {27'($urandom()), 5'd31});
		apb_write(UNUSED_ADDR, $urandom());
		case ($urandom_range(0, 3))
			0: cap_raw = CAP_W'($urandom_range(0, 1));
			1: cap_raw = CAP_W'($urandom_range(2, 8));
			2: cap_raw = CAP_W'($urandom_range(9, 16));
			default: cap_raw = CAP_W'($urandom_range(17, 31));
		endcase
		apb_write(CAP_ADDR, {27'($urandom()), cap_raw});

		@(negedge clk);
		idling_on = 1'b1;
		pending_requests.push_back(mk_req(OP_GET, 32'h8000_0000, 32'h7fff_ffff));
		pending_requests.push_back(mk_req(OP_GET, 32'h7fff_ffff, 32'h8000_0000));
		pending_requests.push_back(mk_req(OP_PUT, 32'h8000_0000, 32'h8000_0000));
		pending_requests.push_back(mk_req(OP_PUT, 32'h7fff_ffff, 32'h7fff_ffff));
		pending_requests.push_back(mk_req(OP_PUT, '0, '0));
		// stored value equal to the miss pattern
		pending_requests.push_back(mk_req(OP_PUT, '1, '1));
		pending_requests.push_back(mk_req(OP_GET, '1, $urandom()));
		pending_requests.push_back(mk_req(OP_PUT, '1, 32'h5a5a_a5a5));
		for (int i = 0; i < capacity; i++) begin
			pending_requests.push_back(mk_req(OP_PUT, 32'(100 + i), $urandom()));
		end
		pending_requests.push_back(mk_req(OP_GET, 32'h8000_0000, '0));
		pending_requests.push_back(mk_req(OP_GET, 32'(100 + capacity - 1), '1));
		wait_drained();

		// store not empty: capacity writes must have no effect
		apb_write(CAP_ADDR, {27'($urandom()), 5'd1});
		run_random(200, 1'b1);
		apb_write(CAP_ADDR, $urandom());
		run_random(200, 1'b1);
		run_random(100, 1'b0);

		repeat (2 * N_LINES + 8) @(posedge clk);
		$display("Run covered %0d transactions, %0d results checked, capacity %0d.",
			accepted, results_checked, capacity);
		$display("Predicted %0d hits and %0d evictions; %0d mismatches.",
			hits_predicted, evictions_predicted, mismatches);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
src/lrukv_pkg.sv
src/lrukv_ram.sv
src/lrukv_ctrl.sv
src/lrukv_dp.sv
src/lru_key_value_cache.sv
bench/tb_lru_key_value_cache.sv
